@@ hdl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and codes of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_TOO_BIG   = 3'd2;
	localparam logic [2:0] ST_NO_BLOCK  = 3'd3;
	localparam logic [2:0] ST_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [15:0] page_count;
		logic [14:0] block_index;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] result_index;
		logic [3:0]  result_order;
		logic [15:0] free_total;
	} rsp_word_t;

endpackage

@@ hdl/bpa_req_if.sv @@
// ----------------------------------------------------------------------------
// bpa_req_if
// command channel with valid / ready handshake
// ----------------------------------------------------------------------------
interface bpa_req_if
	import bpa_pkg::*;
;
	logic      valid;
	logic      ready;
	req_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

@@ hdl/bpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bpa_rsp_if
// result channel with valid / ready handshake
// ----------------------------------------------------------------------------
interface bpa_rsp_if
	import bpa_pkg::*;
;
	logic      valid;
	logic      ready;
	rsp_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

@@ hdl/buddy_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// buddy allocator with free lists kept in one page-indexed memory
// ----------------------------------------------------------------------------
// One command is taken at a time. Page state (free mark, order, next and prev
// links) lives in one synchronous memory with a registered read port; every
// list edit is a read then a write of that memory. A rejected command goes to
// its result word with no list edit; an allocate scans the orders upward,
// unlinks the block found, splits it down and records its order; a free runs
// its checks, merges buddies while they are free, then pushes the block and
// reports. While a result word waits, the next command is taken and runs; it
// holds at its result until the waiting word is taken.
// After reset and after every usable_pages write the block runs a rebuild
// that clears all MAX_PAGES entries, one per cycle, then pushes the greedy
// blocks; no command is taken until it ends.
// free_total is kept as a running count.
module buddy_page_allocator_unit
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = 32768,
	parameter int TOP_ORDER = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	bpa_req_if.sink     req,
	bpa_rsp_if.source   rsp
);
	localparam int AW = $clog2(MAX_PAGES);
	localparam int LW = AW + 1;
	localparam int OW = 4;
	localparam int NO = TOP_ORDER + 1;
	localparam logic [LW-1:0] NIL = LW'(MAX_PAGES);
	localparam int EW = 1 + OW + 2 * LW;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_GREEDY = 5'd1;
	localparam logic [4:0] S_IDLE   = 5'd2;
	localparam logic [4:0] S_DEC    = 5'd3;
	localparam logic [4:0] S_SCAN   = 5'd4;
	localparam logic [4:0] S_UL_RD  = 5'd5;
	localparam logic [4:0] S_UL_WT  = 5'd6;
	localparam logic [4:0] S_UL_P   = 5'd7;
	localparam logic [4:0] S_UL_PW  = 5'd8;
	localparam logic [4:0] S_UL_N   = 5'd9;
	localparam logic [4:0] S_UL_NW  = 5'd10;
	localparam logic [4:0] S_UL_X   = 5'd11;
	localparam logic [4:0] S_PU_H   = 5'd12;
	localparam logic [4:0] S_PU_HW  = 5'd13;
	localparam logic [4:0] S_PU_X   = 5'd14;
	localparam logic [4:0] S_SPLIT  = 5'd15;
	localparam logic [4:0] S_FR_RD  = 5'd16;
	localparam logic [4:0] S_FR_WT  = 5'd17;
	localparam logic [4:0] S_BD_RD  = 5'd18;
	localparam logic [4:0] S_BD_WT  = 5'd19;
	localparam logic [4:0] S_FINAL  = 5'd20;
	localparam logic [4:0] S_OUT    = 5'd21;
	localparam logic [4:0] S_AORD   = 5'd22;
	localparam logic [4:0] S_AORDW  = 5'd23;

	// memory entry: {mark, order, next, prev}
	logic [EW-1:0] mem [MAX_PAGES];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic          rd_mark;
	logic [OW-1:0] rd_ord;
	logic [LW-1:0] rd_next, rd_prev;
	assign {rd_mark, rd_ord, rd_next, rd_prev} = rd_q;

	logic [4:0]    state_q, ret_q;
	logic [LW-1:0] head_q [NO];
	logic [15:0]   cnt_q [NO];
	logic [31:0]   free_q;
	logic [16:0]   usable_q, remain_q;
	logic [LW-1:0] idx_q, p_q, x_q, nxt_q, prv_q;
	logic [OW-1:0] ord_q, cur_q, px_ord_q;
	logic          cmd_q, err_q;
	logic [2:0]    st_q;
	logic [AW:0]   clr_q;
	logic [15:0]   n_q;
	logic [15:0]   base_q;
	logic [OW:0]   need_q;
	logic          rsp_v_q;
	rsp_word_t     rsp_q;
	logic          out_load;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.word  = rsp_q;
	assign out_load  = (state_q == S_OUT) && (!rsp_v_q || rsp.ready);

	// order of the rounded request
	logic [OW:0] need_ord;
	always_comb begin
		need_ord = (OW+1)'(TOP_ORDER + 1);
		for (int i = TOP_ORDER; i >= 0; i--)
			if ({16'd0, n_q} <= (32'd1 << i)) need_ord = (OW+1)'(i);
	end

	// largest greedy order that fits remain
	logic [OW-1:0] g_ord;
	always_comb begin
		g_ord = '0;
		for (int i = 0; i <= TOP_ORDER; i++)
			if ({15'd0, remain_q} >= (32'd1 << i)) g_ord = OW'(i);
	end

	logic [16:0] g_size, c_size;
	assign g_size = 17'd1 << g_ord;
	assign c_size = 17'd1 << cur_q;

	logic [LW-1:0] buddy;
	assign buddy = p_q ^ (LW'(1) << cur_q);

	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
		case (state_q)
			S_CLR: begin
				we = 1'b1; waddr = AW'(clr_q); wdata = {1'b0, {OW{1'b0}}, NIL, NIL};
			end
			S_UL_RD: raddr = AW'(x_q);
			S_UL_P:  raddr = AW'(prv_q);
			S_UL_PW: begin
				we = 1'b1; waddr = AW'(prv_q);
				wdata = {rd_mark, rd_ord, nxt_q, rd_prev};
			end
			S_UL_N:  raddr = AW'(nxt_q);
			S_UL_NW: begin
				we = 1'b1; waddr = AW'(nxt_q);
				wdata = {rd_mark, rd_ord, rd_next, prv_q};
			end
			S_UL_X: begin
				we = 1'b1; waddr = AW'(x_q);
				wdata = {1'b0, px_ord_q, NIL, NIL};
			end
			S_PU_H:  raddr = AW'(head_q[cur_q]);
			S_PU_HW: begin
				we = 1'b1; waddr = AW'(head_q[cur_q]);
				wdata = {rd_mark, rd_ord, rd_next, x_q};
			end
			S_PU_X: begin
				we = 1'b1; waddr = AW'(x_q);
				wdata = {1'b1, cur_q, head_q[cur_q], NIL};
			end
			S_AORD:  raddr = AW'(p_q);
			S_AORDW: begin
				we = 1'b1; waddr = AW'(p_q);
				wdata = {rd_mark, ord_q, rd_next, rd_prev};
			end
			S_FR_RD: raddr = AW'(base_q);
			S_BD_RD: raddr = AW'(buddy);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ret_q    <= S_IDLE;
			clr_q    <= '0;
			usable_q <= 17'(MAX_PAGES);
			remain_q <= 17'(MAX_PAGES);
			idx_q    <= '0;
			free_q   <= '0;
			rsp_v_q  <= 1'b0;
			for (int i = 0; i < NO; i++) begin
				head_q[i] <= NIL;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (rsp_v_q && rsp.ready && !out_load) rsp_v_q <= 1'b0;
			if (cfg_we) begin
				usable_q <= (cfg_wdata == 16'd0) ? 17'd1 :
					({1'b0, cfg_wdata} > 17'(MAX_PAGES)) ? 17'(MAX_PAGES) : {1'b0, cfg_wdata};
				remain_q <= (cfg_wdata == 16'd0) ? 17'd1 :
					({1'b0, cfg_wdata} > 17'(MAX_PAGES)) ? 17'(MAX_PAGES) : {1'b0, cfg_wdata};
				state_q <= S_CLR;
				clr_q   <= '0;
				idx_q   <= '0;
				free_q  <= '0;
				for (int i = 0; i < NO; i++) begin
					head_q[i] <= NIL;
					cnt_q[i]  <= '0;
				end
			end else begin
				case (state_q)
					S_CLR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == (AW+1)'(MAX_PAGES - 1)) state_q <= S_GREEDY;
					end
					S_GREEDY: begin
						if (remain_q == 17'd0) state_q <= S_IDLE;
						else begin
							cur_q    <= g_ord;
							x_q      <= idx_q;
							idx_q    <= idx_q + LW'(g_size);
							remain_q <= remain_q - g_size;
							ret_q    <= S_GREEDY;
							state_q  <= S_PU_H;
						end
					end
					S_IDLE: begin
						if (req.valid) begin
							cmd_q   <= req.word.cmd;
							n_q     <= req.word.page_count;
							base_q  <= {1'b0, req.word.block_index};
							state_q <= S_DEC;
						end
					end
					S_DEC: begin
						need_q <= need_ord;
						ord_q  <= OW'(need_ord);
						cur_q  <= OW'(need_ord);
						p_q    <= LW'(base_q);
						err_q  <= 1'b0;
						st_q   <= ST_OK;
						if (cmd_q == CMD_ALLOC) begin
							if (n_q == 16'd0) begin
								err_q <= 1'b1; st_q <= ST_ZERO; state_q <= S_OUT;
							end else if (need_ord > (OW+1)'(TOP_ORDER)) begin
								err_q <= 1'b1; st_q <= ST_TOO_BIG; state_q <= S_OUT;
							end else state_q <= S_SCAN;
						end else begin
							if (need_ord > (OW+1)'(TOP_ORDER)) begin
								err_q <= 1'b1; st_q <= ST_TOO_BIG; state_q <= S_OUT;
							end else if ({1'b0, base_q} >= usable_q ||
								({1'b0, base_q} + (17'd1 << need_ord)) > usable_q) begin
								err_q <= 1'b1; st_q <= ST_BAD_INDEX; state_q <= S_OUT;
							end else state_q <= S_FR_RD;
						end
					end
					S_SCAN: begin
						if (head_q[cur_q] != NIL) begin
							p_q      <= head_q[cur_q];
							x_q      <= head_q[cur_q];
							px_ord_q <= cur_q;
							ret_q    <= S_SPLIT;
							state_q  <= S_UL_RD;
						end else if (cur_q == OW'(TOP_ORDER)) begin
							err_q <= 1'b1; st_q <= ST_NO_BLOCK; state_q <= S_OUT;
						end else cur_q <= cur_q + 1'b1;
					end
					S_UL_RD: state_q <= S_UL_WT;
					S_UL_WT: begin
						nxt_q <= rd_next;
						prv_q <= rd_prev;
						if (cnt_q[cur_q] != 16'd0) begin
							cnt_q[cur_q] <= cnt_q[cur_q] - 1'b1;
							free_q       <= free_q - 32'(c_size);
						end
						if (rd_prev == NIL) begin
							head_q[cur_q] <= rd_next;
							state_q <= (rd_next != NIL) ? S_UL_N : S_UL_X;
						end else state_q <= S_UL_P;
					end
					S_UL_P:  state_q <= S_UL_PW;
					S_UL_PW: state_q <= (nxt_q != NIL) ? S_UL_N : S_UL_X;
					S_UL_N:  state_q <= S_UL_NW;
					S_UL_NW: state_q <= S_UL_X;
					S_UL_X:  state_q <= ret_q;
					S_PU_H: state_q <= (head_q[cur_q] != NIL) ? S_PU_HW : S_PU_X;
					S_PU_HW: state_q <= S_PU_X;
					S_PU_X: begin
						head_q[cur_q] <= x_q;
						cnt_q[cur_q]  <= cnt_q[cur_q] + 1'b1;
						free_q        <= free_q + 32'(c_size);
						state_q       <= ret_q;
					end
					S_SPLIT: begin
						if ({1'b0, cur_q} > need_q) begin
							cur_q   <= cur_q - 1'b1;
							x_q     <= p_q + (LW'(1) << (cur_q - 1'b1));
							ret_q   <= S_SPLIT;
							state_q <= S_PU_H;
						end else state_q <= S_AORD;
					end
					S_AORD:  state_q <= S_AORDW;
					S_AORDW: state_q <= S_OUT;
					S_FR_RD: state_q <= S_FR_WT;
					S_FR_WT: begin
						if (rd_mark) begin
							err_q <= 1'b1; st_q <= ST_BAD_INDEX; state_q <= S_OUT;
						end else state_q <= S_BD_RD;
					end
					S_BD_RD: begin
						if (cur_q == OW'(TOP_ORDER) || {1'b0, buddy} >= (LW+1)'(usable_q))
							state_q <= S_FINAL;
						else state_q <= S_BD_WT;
					end
					S_BD_WT: begin
						if (rd_mark && rd_ord == cur_q) begin
							x_q      <= buddy;
							px_ord_q <= rd_ord;
							if (buddy < p_q) p_q <= buddy;
							ret_q    <= S_FINAL;
							state_q  <= S_UL_RD;
						end else state_q <= S_FINAL;
					end
					S_FINAL: begin
						if (ret_q == S_FINAL) begin
							// merged one buddy, go up an order
							cur_q   <= cur_q + 1'b1;
							ret_q   <= S_IDLE;
							state_q <= S_BD_RD;
						end else begin
							x_q     <= p_q;
							ret_q   <= S_OUT;
							state_q <= S_PU_H;
						end
					end
					S_OUT: begin
						if (out_load) begin
							rsp_q.status       <= st_q;
							rsp_q.result_index <= err_q ? 15'd0 : 15'(p_q);
							rsp_q.result_order <= err_q ? 4'd0 :
								(cmd_q == CMD_ALLOC ? ord_q : cur_q);
							rsp_q.free_total   <= (free_q > 32'd65535) ? 16'hFFFF : free_q[15:0];
							rsp_v_q            <= 1'b1;
							ret_q              <= S_IDLE;
							state_q            <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule
